[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/hexesc_pkg.sv]
package hexesc_pkg;

    // characters that start an escape
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;

    // warning codes
    localparam logic [1:0] WARN_NONE = 2'd0;
    localparam logic [1:0] WARN_CTRL = 2'd1;
    localparam logic [1:0] WARN_NULL = 2'd2;

    // results one transaction can produce
    localparam int MAX_RESULTS = 4;

    // escape progress: nothing, backslash, backslash x, backslash x digit
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BS    = 2'd1,
        PH_X     = 2'd2,
        PH_DIGIT = 2'd3
    } phase_t;

    // one result transaction
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] warn;
        logic       last;
    } ent_t;

    // everything the decoder hands back for one input transaction
    typedef struct packed {
        phase_t                      phase;
        logic [7:0]                  held;
        logic [2:0]                  count;
        ent_t [MAX_RESULTS-1:0]      ent;
    } dec_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic dig;
        logic low;
        logic upp;
        dig = (c >= 8'h30) && (c <= 8'h39);
        low = (c >= 8'h61) && (c <= 8'h66);
        upp = (c >= 8'h41) && (c <= 8'h46);
        return dig || low || upp;
    endfunction

    // nibble value of a hex digit character; letters map through the low nibble
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c[6])
        begin
            v = c[3:0] + 4'd9;
        end
        else
        begin
            v = c[3:0];
        end
        return v;
    endfunction

    // regex control characters and the null byte get flagged
    function automatic logic [1:0] warn_of(input logic [7:0] v);
        logic [1:0] w;
        unique case (v)
            8'h24, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2E, 8'h3F,
            8'h5B, 8'h5D, 8'h5E, 8'h7C, 8'h7B, 8'h7D, 8'h5C: w = WARN_CTRL;
            8'h00:                                          w = WARN_NULL;
            default:                                        w = WARN_NONE;
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/hexesc_decode.sv]
module hexesc_decode
(
    input  logic [7:0]        cur_byte,
    input  logic              cur_last,
    input  hexesc_pkg::phase_t phase,
    input  logic [7:0]        held,
    output hexesc_pkg::dec_t  dec
);

    logic               broken;
    logic               done;
    logic               lit;
    hexesc_pkg::phase_t nph;
    logic [7:0]         nheld;
    logic [7:0]         dec_byte;
    logic [2:0]         n;
    logic [2:0]         nm1;
    hexesc_pkg::ent_t [hexesc_pkg::MAX_RESULTS-1:0] ent;

    // escape progress for this byte
    always_comb
    begin
        broken = 1'b0;
        done   = 1'b0;
        lit    = 1'b0;
        nph    = phase;
        nheld  = held;
        unique case (phase)
            hexesc_pkg::PH_IDLE:
            begin
                if (cur_byte == hexesc_pkg::CH_BACKSLASH)
                begin
                    nph = hexesc_pkg::PH_BS;
                end
                else
                begin
                    lit = 1'b1;
                end
            end
            hexesc_pkg::PH_BS:
            begin
                if (cur_byte == hexesc_pkg::CH_X)
                begin
                    nph = hexesc_pkg::PH_X;
                end
                else
                begin
                    broken = 1'b1;
                end
            end
            hexesc_pkg::PH_X:
            begin
                if (hexesc_pkg::is_hex(cur_byte))
                begin
                    nheld = cur_byte;
                    nph   = hexesc_pkg::PH_DIGIT;
                end
                else
                begin
                    broken = 1'b1;
                end
            end
            hexesc_pkg::PH_DIGIT:
            begin
                if (hexesc_pkg::is_hex(cur_byte))
                begin
                    done = 1'b1;
                    nph  = hexesc_pkg::PH_IDLE;
                end
                else
                begin
                    broken = 1'b1;
                end
            end
            default:
            begin
                nph = hexesc_pkg::PH_IDLE;
            end
        endcase
        // a breaking byte starts over as if nothing were pending
        if (broken)
        begin
            if (cur_byte == hexesc_pkg::CH_BACKSLASH)
            begin
                nph = hexesc_pkg::PH_BS;
            end
            else
            begin
                nph = hexesc_pkg::PH_IDLE;
                lit = 1'b1;
            end
        end
    end

    assign dec_byte = {hexesc_pkg::hex_value(held), hexesc_pkg::hex_value(cur_byte)};

    // build the ordered result list
    always_comb
    begin
        n   = 3'd0;
        nm1 = 3'd0;
        ent = '0;
        // release held bytes of a broken escape
        if (broken && (phase != hexesc_pkg::PH_IDLE))
        begin
            ent[n[1:0]] = '{hexesc_pkg::CH_BACKSLASH, hexesc_pkg::WARN_NONE, 1'b0};
            n = n + 3'd1;
        end
        if (broken && ((phase == hexesc_pkg::PH_X) || (phase == hexesc_pkg::PH_DIGIT)))
        begin
            ent[n[1:0]] = '{hexesc_pkg::CH_X, hexesc_pkg::WARN_NONE, 1'b0};
            n = n + 3'd1;
        end
        if (broken && (phase == hexesc_pkg::PH_DIGIT))
        begin
            ent[n[1:0]] = '{held, hexesc_pkg::WARN_NONE, 1'b0};
            n = n + 3'd1;
        end
        // completed escape
        if (done)
        begin
            ent[n[1:0]] = '{dec_byte, hexesc_pkg::warn_of(dec_byte), 1'b0};
            n = n + 3'd1;
        end
        // literal pass-through
        if (lit)
        begin
            ent[n[1:0]] = '{cur_byte, hexesc_pkg::WARN_NONE, 1'b0};
            n = n + 3'd1;
        end
        // end of string flushes what is still held
        if (cur_last && (nph != hexesc_pkg::PH_IDLE))
        begin
            ent[n[1:0]] = '{hexesc_pkg::CH_BACKSLASH, hexesc_pkg::WARN_NONE, 1'b0};
            n = n + 3'd1;
        end
        if (cur_last && ((nph == hexesc_pkg::PH_X) || (nph == hexesc_pkg::PH_DIGIT)))
        begin
            ent[n[1:0]] = '{hexesc_pkg::CH_X, hexesc_pkg::WARN_NONE, 1'b0};
            n = n + 3'd1;
        end
        if (cur_last && (nph == hexesc_pkg::PH_DIGIT))
        begin
            ent[n[1:0]] = '{nheld, hexesc_pkg::WARN_NONE, 1'b0};
            n = n + 3'd1;
        end
        // mark the final result of the string
        if (cur_last && (n != 3'd0))
        begin
            nm1 = n - 3'd1;
            ent[nm1[1:0]].last = 1'b1;
        end
    end

    assign dec.phase = cur_last ? hexesc_pkg::PH_IDLE : nph;
    assign dec.held  = nheld;
    assign dec.count = n;
    assign dec.ent   = ent;

endmodule

[hw/rtl/hex_escape_decoder.sv]
// output: the first result of a transaction is registered and offered in the cycle after it is accepted
// throughput: 1 input transaction per cycle while each gives at most one result and
// out_stall is low; a transaction giving more results holds the input until its last
// result is taken, as the result queue drains one entry per cycle while out_stall is low
// reset: rst_n asynchronous active low, clears escape state and empties the queue
module hex_escape_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] warn_code,
    output logic       out_last
);

    hexesc_pkg::phase_t phase_reg;
    hexesc_pkg::phase_t phase_next;
    logic [7:0]         held_reg;
    logic [7:0]         held_next;
    logic [2:0]         rem_reg;
    logic [2:0]         rem_next;
    hexesc_pkg::ent_t [hexesc_pkg::MAX_RESULTS-1:0] ent_reg;
    hexesc_pkg::ent_t [hexesc_pkg::MAX_RESULTS-1:0] ent_next;
    hexesc_pkg::dec_t   dec;
    logic               in_fire;
    logic               out_fire;

    hexesc_decode u_decode
    (
        .cur_byte (in_byte),
        .cur_last (in_last),
        .phase    (phase_reg),
        .held     (held_reg),
        .dec      (dec)
    );

    // handshakes: take a new transaction once the queue is empty or about to be
    assign out_valid = (rem_reg != 3'd0);
    assign out_fire  = out_valid && !out_stall;
    assign in_stall  = !((rem_reg == 3'd0) || ((rem_reg == 3'd1) && out_fire));
    assign in_fire   = in_valid && !in_stall;

    // queue head drives the outputs
    assign out_byte  = ent_reg[0].data;
    assign warn_code = ent_reg[0].warn;
    assign out_last  = ent_reg[0].last;

    // next state of escape tracking and result queue
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        rem_next   = rem_reg;
        ent_next   = ent_reg;
        if (in_fire)
        begin
            phase_next = dec.phase;
            held_next  = dec.held;
            rem_next   = dec.count;
            ent_next   = dec.ent;
        end
        else if (out_fire)
        begin
            rem_next = rem_reg - 3'd1;
            for (int i = 0; i < hexesc_pkg::MAX_RESULTS - 1; i++)
            begin
                ent_next[i] = ent_reg[i+1];
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hexesc_pkg::PH_IDLE;
            held_reg  <= 8'd0;
            rem_reg   <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            rem_reg   <= rem_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

[hw/rtl/hexesc_checker.sv]
`include "assert_macros.svh"

module hexesc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic [1:0] warn_code,
    input logic       out_last
);

    // a stalled result stays offered
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_byte) && $stable(warn_code) && $stable(out_last), "result changed while stalled")

    // end of string always yields at least one result
    `ASSERT_CLK(a_last_emits, clk, rst_n, in_valid && !in_stall && in_last |=> out_valid, "end of string gave no result")

    // with nothing queued the input is never held off
    `ASSERT_CLK(a_no_idle_stall, clk, rst_n, !out_valid |-> !in_stall, "input stalled with empty queue")

    // reset empties the queue
    `ASSERT_CLK_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid, "result offered during reset")

endmodule

bind hex_escape_decoder hexesc_checker u_hexesc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .warn_code (warn_code),
    .out_last  (out_last)
);
